FILE: hdl/pd_turn_with_settle_assert.svh
// assertion macros shared by the turn controller rtl
`ifndef PD_TURN_WITH_SETTLE_ASSERT_SVH
`define PD_TURN_WITH_SETTLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PDT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pd_turn_with_settle assertion failed");

// next-cycle implication, checked outside reset
`define PDT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pd_turn_with_settle assertion failed");

`endif

FILE: hdl/pdt_pkg.sv
// types, widths and constants of the turn controller
package pdt_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int DROP_BITS       = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

  localparam int ANGLE_W   = 32;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int TOL_W     = 16;
  localparam int TMO_W     = 16;
  localparam int LIM_W     = 7;
  localparam int CNT_W     = 4;
  localparam int DRIVE_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // prev_err*kd, err*(kp+kd) and their difference
  localparam int KD_W  = ANGLE_W + GAIN_W;
  localparam int PKD_W = ANGLE_W + GAIN_W + 1;
  localparam int SUM_W = PKD_W + 1;

  localparam logic signed [ANGLE_W-1:0] TARGET_RST = '0;
  localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0]  KD_RST    = GAIN_W'(410);
  localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(256);
  localparam logic [TMO_W-1:0]   TMO_RST   = TMO_W'(3000);
  localparam logic [LIM_W-1:0]   LIM_RST   = LIM_W'(80);
  localparam logic [CNT_W-1:0]   SETTLE_RST = CNT_W'(3);
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_NEEDED = 3'd6;

  typedef enum logic [1:0] {
    STAT_RUNNING = 2'd0,
    STAT_SETTLED = 2'd1,
    STAT_TIMEOUT = 2'd2,
    STAT_DONE    = 2'd3
  } status_t;

  typedef struct packed {
    logic                      restart;
    logic [TIME_W-1:0]         time_ms;
    logic signed [ANGLE_W-1:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    status_t                   status;
  } out_item_t;

endpackage

FILE: hdl/pdt_chan_if.sv
// valid/ready channels for heading samples and drive results
interface pdt_in_if;
  logic              valid;
  logic              ready;
  pdt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdt_out_if;
  logic               valid;
  logic               ready;
  pdt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/pd_turn_with_settle.sv
// pd turn controller with settle and timeout detection, top level
//
// in_ch carries one heading sample per transfer (restart, time_ms, angle);
// out_ch carries one (drive, status) result per sample, in order.
// cfg_we/cfg_index/cfg_wdata write the seven settings; write them only
// while no sample is in flight.
// a sample passes through the input register, the multiply stage and the
// result register on its way to out_ch. throughput: one sample per cycle
// while out_ch.ready does not stall the pipeline; the turn state (previous
// error, settle count, start time, finished) updates as a sample enters
// the result register, so back-to-back samples chain correctly.
// err*(kp+kd) comes from a 32x17 multiplier in the middle stage and
// prev_err*kd from a 32x17 multiplier in the last stage.
// reset: settings go to their defaults, the pipeline empties and the turn
// is finished, so every sample gives drive 0 / status 3 until a restart.
// receiver stall: each stage holds its item; up to three samples are held
// and in_ch.ready falls only when all three stages are full.
`include "pd_turn_with_settle_assert.svh"

module pd_turn_with_settle (
  input  logic                              clk,
  input  logic                              rst_n,
  pdt_in_if.sink                            in_ch,
  pdt_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ANGLE_W = pdt_pkg::ANGLE_W;
  localparam int TIME_W  = pdt_pkg::TIME_W;
  localparam int GAIN_W  = pdt_pkg::GAIN_W;
  localparam int LIM_W   = pdt_pkg::LIM_W;
  localparam int CNT_W   = pdt_pkg::CNT_W;
  localparam int DRIVE_W = pdt_pkg::DRIVE_W;
  localparam int KD_W    = pdt_pkg::KD_W;
  localparam int PKD_W   = pdt_pkg::PKD_W;
  localparam int SUM_W   = pdt_pkg::SUM_W;

  // settings
  logic signed [ANGLE_W-1:0]       target_r;
  logic [GAIN_W-1:0]               kp_r;
  logic [GAIN_W-1:0]               kd_r;
  logic [pdt_pkg::TOL_W-1:0]       tol_r;
  logic [pdt_pkg::TMO_W-1:0]       tmo_r;
  logic [LIM_W-1:0]                limit_r;
  logic [CNT_W-1:0]                settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= pdt_pkg::TARGET_RST;
      kp_r     <= pdt_pkg::KP_RST;
      kd_r     <= pdt_pkg::KD_RST;
      tol_r    <= pdt_pkg::TOL_RST;
      tmo_r    <= pdt_pkg::TMO_RST;
      limit_r  <= pdt_pkg::LIM_RST;
      settle_r <= pdt_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pdt_pkg::REG_TARGET_ANGLE:  target_r <= $signed(cfg_wdata[ANGLE_W-1:0]);
        pdt_pkg::REG_PROP_GAIN:     kp_r     <= cfg_wdata[GAIN_W-1:0];
        pdt_pkg::REG_DERIV_GAIN:    kd_r     <= cfg_wdata[GAIN_W-1:0];
        pdt_pkg::REG_TOLERANCE:     tol_r    <= cfg_wdata[pdt_pkg::TOL_W-1:0];
        pdt_pkg::REG_TIMEOUT_MS:    tmo_r    <= cfg_wdata[pdt_pkg::TMO_W-1:0];
        pdt_pkg::REG_DRIVE_LIMIT:   limit_r  <= cfg_wdata[LIM_W-1:0];
        pdt_pkg::REG_SETTLE_NEEDED: settle_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_adv, s2_adv, out_adv, b_fire;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign s2_adv  = !s2_valid_r || out_adv;
  assign s1_adv  = !s1_valid_r || s2_adv;
  assign b_fire  = s2_valid_r && out_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_ch.valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
      if (out_adv) out_valid_r <= s2_valid_r;
    end
  end

  // stage 1: input register
  pdt_pkg::in_item_t s1_item_r;

  always_ff @(posedge clk) begin
    if (s1_adv) s1_item_r <= in_ch.data;
  end

  // stage 2: saturated error and the combined gain product
  logic signed [ANGLE_W:0]   diff_a;
  logic signed [ANGLE_W-1:0] err_a;
  logic [GAIN_W:0]           kpkd_a;
  logic signed [PKD_W-1:0]   pkd_a;

  always_comb begin
    diff_a = {target_r[ANGLE_W-1], target_r} - {s1_item_r.angle[ANGLE_W-1], s1_item_r.angle};
    if (diff_a[ANGLE_W] != diff_a[ANGLE_W-1]) begin
      err_a = diff_a[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      err_a = diff_a[ANGLE_W-1:0];
    end
    kpkd_a   = {1'b0, kp_r} + {1'b0, kd_r};
    // err*(kp+kd) - prev_err*kd equals kp*err + kd*(err - prev_err)
    pkd_a    = PKD_W'(err_a) * PKD_W'($signed({1'b0, kpkd_a}));
  end

  logic                      s2_restart_r;
  logic [TIME_W-1:0]         s2_time_r;
  logic signed [ANGLE_W-1:0] s2_err_r;
  logic signed [PKD_W-1:0]   s2_pkd_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_restart_r <= s1_item_r.restart;
      s2_time_r    <= s1_item_r.time_ms;
      s2_err_r     <= err_a;
      s2_pkd_r     <= pkd_a;
    end
  end

  // turn state
  logic signed [ANGLE_W-1:0] prev_err_r, prev_err_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TIME_W-1:0]      start_r, start_nxt;
  logic                   fin_r, fin_nxt;

  // stage 3: decisions, previous error times kd, drive scaling and clamp
  logic signed [ANGLE_W-1:0] prev_eff;
  logic signed [KD_W-1:0] prev_kd;
  logic [TIME_W-1:0]      elapsed;
  logic                   timed_out;
  logic [ANGLE_W-1:0]     abs_err;
  logic                   in_band;
  logic [CNT_W-1:0]       cnt_eff, cnt_inc;
  logic                   settled;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]       sum_mag, sum_shift;
  logic                   over;
  logic [LIM_W-1:0]       mag;
  logic [DRIVE_W-1:0]     drive_calc;
  pdt_pkg::out_item_t     res;

  always_comb begin
    start_nxt    = s2_restart_r ? s2_time_r : start_r;
    prev_eff     = s2_restart_r ? '0 : prev_err_r;
    prev_err_nxt = prev_eff;
    cnt_eff      = s2_restart_r ? '0 : cnt_r;
    fin_nxt      = s2_restart_r ? 1'b0 : fin_r;
    cnt_nxt      = cnt_eff;

    elapsed   = s2_time_r - start_nxt;
    timed_out = elapsed > TIME_W'(tmo_r);
    abs_err   = s2_err_r[ANGLE_W-1] ? (ANGLE_W'(0) - s2_err_r) : s2_err_r;
    in_band   = abs_err < ANGLE_W'(tol_r);
    cnt_inc   = (cnt_eff == pdt_pkg::CNT_MAX) ? cnt_eff : cnt_eff + CNT_W'(1);
    settled   = in_band && (cnt_inc >= settle_r);

    // the current kd setting applies to the stored previous error
    prev_kd   = KD_W'(prev_eff) * KD_W'($signed({1'b0, kd_r}));
    sum       = SUM_W'(s2_pkd_r) - SUM_W'(prev_kd);
    sum_mag   = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    sum_shift = sum_mag >> pdt_pkg::DROP_BITS;
    over      = (|sum_shift[SUM_W-1:LIM_W]) || (sum_shift[LIM_W-1:0] > limit_r);
    mag       = over ? limit_r : sum_shift[LIM_W-1:0];
    drive_calc = sum[SUM_W-1] ? (DRIVE_W'(0) - {1'b0, mag}) : {1'b0, mag};

    res.drive  = '0;
    res.status = pdt_pkg::STAT_DONE;
    if (fin_nxt) begin
      res.status = pdt_pkg::STAT_DONE;
    end else if (timed_out) begin
      fin_nxt    = 1'b1;
      res.status = pdt_pkg::STAT_TIMEOUT;
    end else if (settled) begin
      cnt_nxt    = cnt_inc;
      fin_nxt    = 1'b1;
      res.status = pdt_pkg::STAT_SETTLED;
    end else begin
      cnt_nxt      = in_band ? cnt_inc : '0;
      prev_err_nxt = s2_err_r;
      res.status   = pdt_pkg::STAT_RUNNING;
      res.drive    = $signed(drive_calc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      cnt_r      <= '0;
      start_r    <= '0;
      fin_r      <= 1'b1;
    end else if (b_fire) begin
      prev_err_r <= prev_err_nxt;
      cnt_r      <= cnt_nxt;
      start_r    <= start_nxt;
      fin_r      <= fin_nxt;
    end
  end

  // result register
  pdt_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (out_adv) out_item_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // only a running sample may carry a nonzero drive
  `PDT_ASSERT_NOW(a_drive_zero_when_final, clk, rst_n,
    out_valid_r && (out_item_r.status != pdt_pkg::STAT_RUNNING), out_item_r.drive == '0)

  // drive stays inside the clamp
  `PDT_ASSERT_NOW(a_drive_clamped, clk, rst_n, out_valid_r,
    (out_item_r.drive <= $signed({1'b0, limit_r}))
      && (out_item_r.drive >= -$signed({1'b0, limit_r})))

  // any terminal result leaves the turn finished
  `PDT_ASSERT_NEXT(a_final_sets_finished, clk, rst_n,
    b_fire && (res.status != pdt_pkg::STAT_RUNNING), fin_r)

  // a running result leaves the turn open
  `PDT_ASSERT_NEXT(a_running_keeps_open, clk, rst_n,
    b_fire && (res.status == pdt_pkg::STAT_RUNNING), !fin_r)

endmodule

FILE: tb/tb_pd_turn_with_settle.sv
// testbench for the pd turn controller: directed turns, random turns, idling and stalls
module tb_pd_turn_with_settle;

  localparam int CFG_IDX_W  = pdt_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pdt_pkg::CFG_DATA_W;
  localparam int ANGLE_W    = pdt_pkg::ANGLE_W;
  localparam int TIME_W     = pdt_pkg::TIME_W;
  localparam int GAIN_W     = pdt_pkg::GAIN_W;
  localparam int TOL_W      = pdt_pkg::TOL_W;
  localparam int TMO_W      = pdt_pkg::TMO_W;
  localparam int LIM_W      = pdt_pkg::LIM_W;
  localparam int CNT_W      = pdt_pkg::CNT_W;
  localparam int DRIVE_W    = pdt_pkg::DRIVE_W;

  localparam longint ERR_MAX = (longint'(1) <<< 31) - 1;
  localparam longint ERR_MIN = -(longint'(1) <<< 31);

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pdt_in_if in_ch ();
  pdt_out_if out_ch ();

  pd_turn_with_settle DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // settings as the controller holds them
  logic signed [ANGLE_W-1:0] tgt_ang;
  logic [GAIN_W-1:0] kp;
  logic [GAIN_W-1:0] kd;
  logic [TOL_W-1:0] tol_band;
  logic [TMO_W-1:0] tmo;
  logic [LIM_W-1:0] lim;
  logic [CNT_W-1:0] settle_req;

  // turn state
  logic signed [ANGLE_W-1:0] last_err;
  logic [CNT_W-1:0] band_cnt;
  logic [TIME_W-1:0] turn_t0;
  logic turn_over;

  pdt_pkg::out_item_t drive_status_q[$];
  pdt_pkg::out_item_t got_want;
  bit in_gap_on;
  bit out_stall_on;
  int out_hold;
  int n_bad;
  int n_sent;
  int n_results;
  int n_settled;
  int n_timeout;
  int n_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #(12 * 200000);
    $display("tb_pd_turn_with_settle failed");
    $finish;
  end

  // next drive/status for one sample, advancing the turn state
  function automatic pdt_pkg::out_item_t turn_step(pdt_pkg::in_item_t s);
    pdt_pkg::out_item_t r;
    longint e;
    longint d;
    longint acc;
    longint mag;
    logic [TIME_W-1:0] dt;
    r.drive = '0;
    r.status = pdt_pkg::STAT_RUNNING;
    if (s.restart) begin
      turn_t0 = s.time_ms;
      last_err = '0;
      band_cnt = '0;
      turn_over = 1'b0;
    end
    if (turn_over) begin
      r.status = pdt_pkg::STAT_DONE;
      return r;
    end
    dt = s.time_ms - turn_t0;
    if (dt > TIME_W'(tmo)) begin
      turn_over = 1'b1;
      r.status = pdt_pkg::STAT_TIMEOUT;
      return r;
    end
    e = longint'($signed(tgt_ang)) - longint'($signed(s.angle));
    if (e > ERR_MAX) e = ERR_MAX;
    if (e < ERR_MIN) e = ERR_MIN;
    mag = (e < 0) ? -e : e;
    if (mag < longint'(tol_band)) begin
      if (band_cnt != pdt_pkg::CNT_MAX) band_cnt++;
      if (band_cnt >= settle_req) begin
        turn_over = 1'b1;
        r.status = pdt_pkg::STAT_SETTLED;
        return r;
      end
    end else begin
      band_cnt = '0;
    end
    d = e - longint'($signed(last_err));
    acc = e * longint'(kp) + d * longint'(kd);
    mag = ((acc < 0) ? -acc : acc) >>> pdt_pkg::DROP_BITS;
    if (mag > longint'(lim)) mag = longint'(lim);
    r.drive = DRIVE_W'((acc < 0) ? -mag : mag);
    last_err = ANGLE_W'(e);
    return r;
  endfunction

  task automatic note_mismatch(string what);
    n_bad++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // result side: compare every transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (drive_status_q.size() == 0) begin
        note_mismatch($sformatf("result drive %0d status %0d with nothing pending",
                                out_ch.data.drive, out_ch.data.status));
      end else begin
        got_want = drive_status_q.pop_front();
        if (out_ch.data.drive !== got_want.drive)
          note_mismatch($sformatf("drive %0d, predicted %0d", out_ch.data.drive,
                                  got_want.drive));
        if (out_ch.data.status !== got_want.status)
          note_mismatch($sformatf("status %0d, predicted %0d", out_ch.data.status,
                                  got_want.status));
      end
      out_hold = out_stall_on ? $urandom_range(0, 4) : 0;
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold--;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_sample(logic rs, logic [TIME_W-1:0] t, logic [ANGLE_W-1:0] a);
    pdt_pkg::in_item_t s;
    pdt_pkg::out_item_t r;
    int gap;
    s.restart = rs;
    s.time_ms = t;
    s.angle = a;
    gap = in_gap_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = turn_step(s);
    drive_status_q.push_back(r);
    n_sent++;
    case (r.status)
      pdt_pkg::STAT_SETTLED: n_settled++;
      pdt_pkg::STAT_TIMEOUT: n_timeout++;
      pdt_pkg::STAT_DONE: n_done++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (drive_status_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pdt_pkg::REG_TARGET_ANGLE: tgt_ang = val;
      pdt_pkg::REG_PROP_GAIN: kp = val[GAIN_W-1:0];
      pdt_pkg::REG_DERIV_GAIN: kd = val[GAIN_W-1:0];
      pdt_pkg::REG_TOLERANCE: tol_band = val[TOL_W-1:0];
      pdt_pkg::REG_TIMEOUT_MS: tmo = val[TMO_W-1:0];
      pdt_pkg::REG_DRIVE_LIMIT: lim = val[LIM_W-1:0];
      pdt_pkg::REG_SETTLE_NEEDED: settle_req = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_all(logic [31:0] target, logic [31:0] p, logic [31:0] dg,
                         logic [31:0] band, logic [31:0] to, logic [31:0] clamp,
                         logic [31:0] need);
    cfg_write(pdt_pkg::REG_TARGET_ANGLE, target);
    cfg_write(pdt_pkg::REG_PROP_GAIN, p);
    cfg_write(pdt_pkg::REG_DERIV_GAIN, dg);
    cfg_write(pdt_pkg::REG_TOLERANCE, band);
    cfg_write(pdt_pkg::REG_TIMEOUT_MS, to);
    cfg_write(pdt_pkg::REG_DRIVE_LIMIT, clamp);
    cfg_write(pdt_pkg::REG_SETTLE_NEEDED, need);
  endtask

  // out of reset the turn is finished until a restart
  task automatic test_idle_after_reset();
    send_sample(1'b0, 32'd100, 32'd0);
    send_sample(1'b0, 32'd101, 32'hFFFF_0000);
  endtask

  // first sample uses its error as derivative, then settles on default settings
  task automatic test_first_sample_and_settle();
    send_sample(1'b1, 32'd1000, -(32'sd10 <<< 8));
    send_sample(1'b0, 32'd1010, -(32'sd3 <<< 8));
    send_sample(1'b0, 32'd1020, 32'sd100);
    send_sample(1'b0, 32'd1030, -32'sd255);
    send_sample(1'b0, 32'd1040, 32'sd0);
    send_sample(1'b0, 32'd1050, 32'sd0);
    send_sample(1'b1, 32'd2000, 32'sd4000);
    send_sample(1'b1, 32'd2005, -32'sd70000);
  endtask

  // error saturation both ways, largest gains and clamps
  task automatic test_saturation_extremes();
    drain();
    cfg_all(32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF, 32'd0, 32'hFFFF, 32'd127, 32'd1);
    send_sample(1'b1, 32'hFFFF_FFFF, 32'h8000_0000);
    send_sample(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    drain();
    cfg_write(pdt_pkg::REG_TARGET_ANGLE, 32'h8000_0000);
    send_sample(1'b1, 32'd0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'd1, 32'h8000_0000);
    drain();
    cfg_write(pdt_pkg::REG_DRIVE_LIMIT, 32'd0);
    send_sample(1'b1, 32'd5, 32'h0000_1000);
    drain();
    cfg_all(32'd0, 32'd0, 32'd0, 32'd256, 32'd3000, 32'd127, 32'd3);
    send_sample(1'b1, 32'd5, 32'h0010_0000);
  endtask

  // zero timeout, then elapsed time across the 32-bit wrap
  task automatic test_timeout_and_wrap();
    drain();
    cfg_all(32'd0, 32'd2048, 32'd410, 32'd256, 32'd0, 32'd80, 32'd3);
    send_sample(1'b1, 32'd5, 32'd5000);
    send_sample(1'b0, 32'd5, 32'd4000);
    send_sample(1'b0, 32'd6, 32'd3000);
    send_sample(1'b0, 32'd7, 32'd2000);
    drain();
    cfg_write(pdt_pkg::REG_TIMEOUT_MS, 32'd100);
    send_sample(1'b1, 32'hFFFF_FFF0, 32'd9000);
    send_sample(1'b0, 32'h0000_0010, 32'd8000);
    send_sample(1'b0, 32'h0000_0080, 32'd7000);
  endtask

  // zero samples needed: an in-band first sample ends the turn
  task automatic test_zero_settle();
    drain();
    cfg_all(32'd0, 32'd2048, 32'd410, 32'hFFFF, 32'd3000, 32'd80, 32'd0);
    send_sample(1'b1, 32'd50, -32'sd65534);
    send_sample(1'b1, 32'd60, -32'sd65535);
  endtask

  // one setting, then turns converging on the target mixed with noise samples
  task automatic run_phase(int n_items, int shape);
    int sent;
    int len;
    int off;
    int near;
    int k;
    logic [TIME_W-1:0] t;
    logic [ANGLE_W-1:0] a;
    drain();
    case (shape)
      0: cfg_all($urandom, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd127, 32'd15);
      1: cfg_all($urandom, 32'd0, 32'hFFFF, 32'd0, 32'd0, 32'd127, 32'd1);
      2: cfg_all($urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 4096), 32'hFFFF, 32'd0, $urandom_range(0, 15));
      default: cfg_all($urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 4096), $urandom_range(200, 65535),
                       $urandom_range(0, 127), $urandom_range(0, 15));
    endcase
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(1'($urandom_range(0, 1)), $urandom, $urandom);
        sent++;
      end else begin
        len = $urandom_range(2, 20);
        t = $urandom;
        off = int'($urandom_range(0, 1 << 18)) - (1 << 17);
        for (k = 0; k < len && sent < n_items; k++) begin
          if (k > 0) begin
            // an occasional long gap runs past the timeout
            t += ($urandom_range(0, 24) == 0) ? $urandom_range(0, 70000)
                                               : $urandom_range(1, 60);
            off = off / int'($urandom_range(1, 3));
          end
          near = int'($urandom_range(0, 2 * tol_band)) - int'(tol_band);
          a = tgt_ang - ((k > len / 2) ? near : off);
          // now and then a turn starts without its restart
          send_sample(k == 0 && $urandom_range(0, 15) != 0, t, a);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_turns();
    int p;
    for (p = 0; p < 7; p++) begin
      in_gap_on = (p % 3) != 0;
      out_stall_on = (p % 3) != 1;
      run_phase(128, p);
    end
  endtask

  task automatic test_back_to_back();
    in_gap_on = 1'b0;
    out_stall_on = 1'b0;
    run_phase(128, 3);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    out_hold = 0;
    in_gap_on = 1'b1;
    out_stall_on = 1'b1;
    n_bad = 0;
    n_sent = 0;
    n_results = 0;
    n_settled = 0;
    n_timeout = 0;
    n_done = 0;
    tgt_ang = pdt_pkg::TARGET_RST;
    kp = pdt_pkg::KP_RST;
    kd = pdt_pkg::KD_RST;
    tol_band = pdt_pkg::TOL_RST;
    tmo = pdt_pkg::TMO_RST;
    lim = pdt_pkg::LIM_RST;
    settle_req = pdt_pkg::SETTLE_RST;
    last_err = '0;
    band_cnt = '0;
    turn_t0 = '0;
    turn_over = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_after_reset();
    test_first_sample_and_settle();
    test_saturation_extremes();
    test_timeout_and_wrap();
    test_zero_settle();
    test_random_turns();
    test_back_to_back();
    drain();
    repeat (10) @(negedge clk);

    $display("ran %0d samples, checked %0d results, %0d mismatches", n_sent, n_results, n_bad);
    $display("turn endings: %0d settled, %0d timed out, %0d samples after finish",
             n_settled, n_timeout, n_done);
    if (n_bad == 0) begin
      $display("tb_pd_turn_with_settle passed");
    end else begin
      $display("tb_pd_turn_with_settle failed");
    end
    $finish;
  end

endmodule
